// File: rtl/stereo_mixer_dc_blocker_unit_macros.svh
// Assertion macros shared by the stereo mixer / DC blocker RTL.
// Each macro expects a clock named clk and a synchronous active-low reset rst_n in scope.
`ifndef STEREO_MIXER_DC_BLOCKER_UNIT_MACROS_SVH
`define STEREO_MIXER_DC_BLOCKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SMDC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SMDC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/smdc_pkg.sv
// Shared constants, types and width helpers for the stereo mixer / DC blocker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smdc_pkg;

  localparam int MAX_SOURCES     = 4;
  localparam int NUM_SOURCES_DEF = 4;
  localparam int DC_SHIFT_DEF    = 9;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int STATE_W  = 40;

  // sum unit 2^-29 -> filter unit 2^-20 -> output unit 2^-15
  localparam int X_SHIFT     = 9;
  localparam int OUT_SHIFT   = 5;
  localparam int QUIET_LIMIT = 32;

  localparam int GAINS_W    = 4 * GAIN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAINS_W;

  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MASK = CFG_IDX_W'(MAX_SOURCES);

  localparam int MASK_LSB    = 2 * SAMPLE_W * MAX_SOURCES;
  localparam int IN_TDATA_W  = ((MASK_LSB + MAX_SOURCES + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * SAMPLE_W;

  typedef struct packed {
    logic signed [PROD_W-1:0] pr2;
    logic signed [PROD_W-1:0] pr1;
    logic signed [PROD_W-1:0] pl2;
    logic signed [PROD_W-1:0] pl1;
  } lane_prod_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } flt_ctrl_t;

  // Mix accumulator width for n sources (2n products per channel).
  function automatic int acc_width(input int n);
    return PROD_W + $clog2(2 * n);
  endfunction

  // Filter input width after rounding the mix down by X_SHIFT bits.
  function automatic int x_width(input int n);
    return acc_width(n) + 1 - X_SHIFT;
  endfunction

endpackage

// File: rtl/smdc_lane.sv
// One mixer lane: four gain-by-sample products for a single source, registered.
// Depends on smdc_pkg.
`timescale 1ns / 1ps

module smdc_lane
  import smdc_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [SAMPLE_W-1:0] sample_l,
  input  logic signed [SAMPLE_W-1:0] sample_r,
  input  logic        [GAINS_W-1:0]  gains,
  input  logic                       use_l,
  input  logic                       use_r,
  output lane_prod_t                 prod_r
);

  logic signed [SAMPLE_W-1:0] sl;
  logic signed [SAMPLE_W-1:0] sr;
  logic signed [GAIN_W-1:0]   g_l1;
  logic signed [GAIN_W-1:0]   g_l2;
  logic signed [GAIN_W-1:0]   g_r1;
  logic signed [GAIN_W-1:0]   g_r2;
  lane_prod_t                 prod_nxt;

  // inactive source contributes nothing; mono source drops its right sample
  assign sl   = use_l ? sample_l : '0;
  assign sr   = use_r ? sample_r : '0;
  assign g_l1 = $signed(gains[0*GAIN_W +: GAIN_W]);
  assign g_l2 = $signed(gains[1*GAIN_W +: GAIN_W]);
  assign g_r1 = $signed(gains[2*GAIN_W +: GAIN_W]);
  assign g_r2 = $signed(gains[3*GAIN_W +: GAIN_W]);

  always_comb begin
    prod_nxt.pl1 = g_l1 * sl;
    prod_nxt.pl2 = g_l2 * sr;
    prod_nxt.pr1 = g_r1 * sl;
    prod_nxt.pr2 = g_r2 * sr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: rtl/smdc_merge.sv
// Merge stage: sums the lane products per channel and rounds to the filter input unit.
// Depends on smdc_pkg and the lane product type.
`timescale 1ns / 1ps

module smdc_merge
  import smdc_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  lane_prod_t [NUM_SOURCES-1:0]          prod,
  output logic signed [x_width(NUM_SOURCES)-1:0] x_l_r,
  output logic signed [x_width(NUM_SOURCES)-1:0] x_r_r
);

  localparam int ACC_W = acc_width(NUM_SOURCES);
  localparam int X_W   = x_width(NUM_SOURCES);

  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W:0]   rnd_l;
  logic signed [ACC_W:0]   rnd_r;
  logic signed [X_W-1:0]   x_l_nxt;
  logic signed [X_W-1:0]   x_r_nxt;

  always_comb begin
    acc_l = '0;
    acc_r = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      acc_l = acc_l + ACC_W'($signed(prod[s].pl1)) + ACC_W'($signed(prod[s].pl2));
      acc_r = acc_r + ACC_W'($signed(prod[s].pr1)) + ACC_W'($signed(prod[s].pr2));
    end
    // round half up, then floor shift
    rnd_l   = (ACC_W+1)'(acc_l) + (ACC_W+1)'(1 << (X_SHIFT - 1));
    rnd_r   = (ACC_W+1)'(acc_r) + (ACC_W+1)'(1 << (X_SHIFT - 1));
    x_l_nxt = X_W'(rnd_l >>> X_SHIFT);
    x_r_nxt = X_W'(rnd_r >>> X_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_l_r <= x_l_nxt;
      x_r_r <= x_r_nxt;
    end
  end

endmodule

// File: rtl/smdc_dc_filter.sv
// One-channel DC blocker: t1 = t0 - floor(t0 / 2^DC_SHIFT) + x, y = t1 - t0.
// Depends on smdc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "stereo_mixer_dc_blocker_unit_macros.svh"

module smdc_dc_filter
  import smdc_pkg::*;
#(
  parameter int DC_SHIFT = DC_SHIFT_DEF,
  parameter int X_W      = x_width(NUM_SOURCES_DEF)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  flt_ctrl_t                 ctrl,
  input  logic signed [X_W-1:0]     x,
  output logic                      quiet,
  output logic signed [STATE_W:0]   y_r
);

  localparam logic signed [STATE_W-1:0] QUIET_HI = STATE_W'(QUIET_LIMIT);
  localparam logic signed [STATE_W-1:0] ST_MAX   = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN   = {1'b1, {(STATE_W-1){1'b0}}};

  logic signed [STATE_W-1:0] state_r;
  logic signed [STATE_W-1:0] state_nxt;
  logic signed [STATE_W-1:0] leak;
  logic signed [STATE_W+1:0] sum;
  logic signed [STATE_W:0]   y_nxt;

  assign quiet = (state_r < QUIET_HI) && (state_r > -QUIET_HI);

  always_comb begin
    leak = state_r >>> DC_SHIFT;
    sum  = (STATE_W+2)'(state_r) - (STATE_W+2)'(leak) + (STATE_W+2)'(x);
    // saturate to the state range when the top three bits disagree
    if ((&sum[STATE_W+1:STATE_W-1]) || !(|sum[STATE_W+1:STATE_W-1])) begin
      state_nxt = sum[STATE_W-1:0];
    end else if (sum[STATE_W+1]) begin
      state_nxt = ST_MIN;
    end else begin
      state_nxt = ST_MAX;
    end
    y_nxt = (STATE_W+1)'(state_nxt) - (STATE_W+1)'(state_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (ctrl.advance) begin
      state_r <= ctrl.clear ? '0 : state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      y_r <= ctrl.clear ? '0 : y_nxt;
    end
  end

  `SMDC_ASSERT_NXT(a_clear_zeroes, ctrl.advance && ctrl.clear, state_r == '0 && y_r == '0, "filter clear did not zero state and output")
  `SMDC_ASSERT_NXT(a_state_holds, !ctrl.advance, $stable(state_r), "filter state moved without an advancing frame")

endmodule

// File: rtl/stereo_mixer_dc_blocker_unit.sv
// An input transfer reaches out_tvalid through the lane, merge, filter and output
// registers; the lane register loads at the transfer edge itself.
// Throughput: one frame per cycle unless out_tready stalls; each stage advances when the
// stage after it is empty or moving, so an input is taken while a result waits in the
// output register if an earlier stage is empty. The filter recurrence sets the frame rate.
// Reset (rst_n low, synchronous): clears gains, stereo mask, filter states, valid flags.
`timescale 1ns / 1ps
`include "stereo_mixer_dc_blocker_unit_macros.svh"

module stereo_mixer_dc_blocker_unit
  import smdc_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int DC_SHIFT    = DC_SHIFT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // src0_left, src0_right, src1_left, src1_right, src2_left, src2_right,
  // src3_left, src3_right, active_mask, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_left, out_right
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int X_W = x_width(NUM_SOURCES);

  logic [GAINS_W-1:0]     gains_r [NUM_SOURCES];
  logic [MAX_SOURCES-1:0] stereo_mask_r;

  logic v1_r, v2_r, v3_r, out_tvalid_r;
  logic en1, en2, en3, en4;
  logic silent1_r, silent2_r;

  logic [NUM_SOURCES-1:0]        active;
  lane_prod_t [NUM_SOURCES-1:0]  prod;
  logic signed [X_W-1:0]         x_l;
  logic signed [X_W-1:0]         x_r;
  flt_ctrl_t                     flt_ctrl;
  logic                          quiet_l;
  logic                          quiet_r;
  logic signed [STATE_W:0]       y_l;
  logic signed [STATE_W:0]       y_r;
  logic [OUT_TDATA_W-1:0]        out_tdata_r;

  function automatic logic [SAMPLE_W-1:0] to_sample(input logic signed [STATE_W:0] y);
    logic signed [STATE_W+1:0] r;
    r = ((STATE_W+2)'(y) + (STATE_W+2)'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if ((&r[STATE_W+1:SAMPLE_W-1]) || !(|r[STATE_W+1:SAMPLE_W-1])) begin
      return r[SAMPLE_W-1:0];
    end else if (r[STATE_W+1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        gains_r[s] <= '0;
      end
      stereo_mask_r <= '0;
    end else if (cfg_valid) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        if (cfg_index == CFG_IDX_W'(s)) begin
          gains_r[s] <= cfg_data;
        end
      end
      if (cfg_index == REG_STEREO_MASK) begin
        stereo_mask_r <= cfg_data[MAX_SOURCES-1:0];
      end
    end
  end

  // stall chain: a stage advances when its successor is empty or advancing
  assign en4       = !out_tvalid_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  assign active = in_tdata[MASK_LSB +: NUM_SOURCES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) out_tvalid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) silent1_r <= !(|active);
    if (en2) silent2_r <= silent1_r;
  end

  for (genvar s = 0; s < NUM_SOURCES; s++) begin : g_lane
    smdc_lane u_lane (
      .clk      (clk),
      .en       (en1),
      .sample_l ($signed(in_tdata[(2*s)*SAMPLE_W +: SAMPLE_W])),
      .sample_r ($signed(in_tdata[(2*s+1)*SAMPLE_W +: SAMPLE_W])),
      .gains    (gains_r[s]),
      .use_l    (active[s]),
      .use_r    (active[s] && stereo_mask_r[s]),
      .prod_r   (prod[s])
    );
  end

  smdc_merge #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_merge (
    .clk   (clk),
    .en    (en2),
    .prod  (prod),
    .x_l_r (x_l),
    .x_r_r (x_r)
  );

  // silent frame with both states near zero: clear states and emit zero
  always_comb begin
    flt_ctrl.advance = v2_r && en3;
    flt_ctrl.clear   = silent2_r && quiet_l && quiet_r;
  end

  smdc_dc_filter #(
    .DC_SHIFT (DC_SHIFT),
    .X_W      (X_W)
  ) u_filt_l (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (flt_ctrl),
    .x     (x_l),
    .quiet (quiet_l),
    .y_r   (y_l)
  );

  smdc_dc_filter #(
    .DC_SHIFT (DC_SHIFT),
    .X_W      (X_W)
  ) u_filt_r (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (flt_ctrl),
    .x     (x_r),
    .quiet (quiet_r),
    .y_r   (y_r)
  );

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      out_tdata_r <= {to_sample(y_r), to_sample(y_l)};
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  `SMDC_ASSERT_IMP(a_ready_when_empty, !out_tvalid_r && !v3_r, in_tready, "input stalled with an empty output side")
  `SMDC_ASSERT_NXT(a_merge_holds, v2_r && !en3, v2_r && $stable(x_l) && $stable(x_r), "merge stage lost a stalled frame")
  `SMDC_ASSERT_NXT(a_filter_feeds_out, v3_r && en4, out_tvalid_r, "filtered frame did not reach the output register")

endmodule
